// ===== src/ppd_pkg.sv =====
// ----------------------------------------------------------------------------
// ppd_pkg
// Shared widths, register map and reset values for the path point downsampler.
// ----------------------------------------------------------------------------
package ppd_pkg;

  localparam int COORD_WIDTH  = 24;
  localparam int STEP_WIDTH   = 16;
  localparam int THRESH_WIDTH = 50;

  localparam int DATA_WIDTH     = ((3 * COORD_WIDTH + 7) / 8) * 8;
  localparam int CFG_DATA_WIDTH = 64;
  localparam int CFG_ADDR_WIDTH = 5;

  localparam int SQ_WIDTH  = 2 * COORD_WIDTH;
  localparam int SUM_WIDTH = SQ_WIDTH + 2;
  localparam int CMP_WIDTH = (SUM_WIDTH > THRESH_WIDTH) ? SUM_WIDTH : THRESH_WIDTH;

  localparam logic [STEP_WIDTH-1:0]   STEP_RESET   = STEP_WIDTH'(5);
  localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = THRESH_WIDTH'(250000);

  typedef enum logic {
    MODE_STEP = 1'b0,
    MODE_DIST = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_STEP   = 2'd1,
    REG_THRESH = 2'd2
  } reg_idx_t;

endpackage

// ===== src/path_point_downsampler.sv =====
// ----------------------------------------------------------------------------
// path_point_downsampler
// Flags the points of a streamed 3D path to keep, by step index or distance.
// ----------------------------------------------------------------------------
// Each point is registered in the input stage and then in the result stage;
// out_tvalid rises once the result stage is loaded. Throughput: one point per
// cycle while the output is not stalled, bounded by the loop from the kept-point
// registers through the squared-distance compare back to them.
// Reset (rst_n low, synchronous): pipeline emptied, phase and kept point
// cleared, mode = step, step_size = 5, dist_thresh_sq = 250000.
module path_point_downsampler (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: x_pos, y_pos, z_pos (lowest bits first)
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [ppd_pkg::DATA_WIDTH-1:0]      in_tdata,
  input  logic                                in_tlast,
  // in_tuser: path_start
  input  logic                                in_tuser,
  // out_tdata: out_x, out_y, out_z (lowest bits first)
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [ppd_pkg::DATA_WIDTH-1:0]      out_tdata,
  output logic                                out_tlast,
  // out_tuser: keep
  output logic                                out_tuser,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [ppd_pkg::CFG_ADDR_WIDTH-1:0]  cfg_paddr,
  input  logic [ppd_pkg::CFG_DATA_WIDTH-1:0]  cfg_pwdata,
  output logic [ppd_pkg::CFG_DATA_WIDTH-1:0]  cfg_prdata,
  output logic                                cfg_pready
);
  import ppd_pkg::*;

  localparam int PAD_WIDTH = DATA_WIDTH - 3 * COORD_WIDTH;

  function automatic logic [COORD_WIDTH-1:0] abs_diff(
    input logic signed [COORD_WIDTH-1:0] a,
    input logic signed [COORD_WIDTH-1:0] b
  );
    logic signed [COORD_WIDTH:0] d;
    logic        [COORD_WIDTH:0] m;
    d = {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
    m = d[COORD_WIDTH] ? (~d + 1'b1) : d;
    return m[COORD_WIDTH-1:0];
  endfunction

  // configuration registers
  mode_t                   mode_r;
  logic [STEP_WIDTH-1:0]   step_r;
  logic [THRESH_WIDTH-1:0] thresh_r;
  logic                    cfg_wr;
  reg_idx_t                cfg_idx;

  // input stage
  logic                          s1_valid_r;
  logic signed [COORD_WIDTH-1:0] s1_x_r, s1_y_r, s1_z_r;
  logic                          s1_start_r, s1_end_r;

  // block state
  logic signed [COORD_WIDTH-1:0] kept_x_r, kept_y_r, kept_z_r;
  logic [STEP_WIDTH-1:0]         phase_r;

  // result stage
  logic                          out_valid_r;
  logic signed [COORD_WIDTH-1:0] out_x_r, out_y_r, out_z_r;
  logic                          out_keep_r, out_end_r;

  logic                    adv;
  logic                    in_xfer;
  logic                    fire;
  logic [COORD_WIDTH-1:0]  ax, ay, az;
  logic [SQ_WIDTH-1:0]     sq_x, sq_y, sq_z;
  logic [SUM_WIDTH-1:0]    dist_sq;
  logic                    far;
  logic [STEP_WIDTH-1:0]   phase;
  logic [STEP_WIDTH:0]     phase_inc;
  logic [STEP_WIDTH-1:0]   phase_nxt;
  logic                    keep_nxt;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[CFG_ADDR_WIDTH-1:3]);

  always_comb begin
    unique case (cfg_idx)
      REG_MODE:   cfg_prdata = CFG_DATA_WIDTH'(mode_r);
      REG_STEP:   cfg_prdata = CFG_DATA_WIDTH'(step_r);
      REG_THRESH: cfg_prdata = CFG_DATA_WIDTH'(thresh_r);
      default:    cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_STEP;
      step_r   <= STEP_RESET;
      thresh_r <= THRESH_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MODE:   mode_r   <= mode_t'(cfg_pwdata[0]);
        REG_STEP:   step_r   <= cfg_pwdata[STEP_WIDTH-1:0];
        REG_THRESH: thresh_r <= cfg_pwdata[THRESH_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign adv       = ~out_valid_r | out_tready;
  assign in_tready = ~s1_valid_r | adv;
  assign in_xfer   = in_tvalid & in_tready;
  assign fire      = s1_valid_r & adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_xfer | (s1_valid_r & ~adv);
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_x_r     <= in_tdata[COORD_WIDTH-1:0];
      s1_y_r     <= in_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
      s1_z_r     <= in_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];
      s1_start_r <= in_tuser;
      s1_end_r   <= in_tlast;
    end
  end

  // keep decision
  always_comb begin
    ax      = abs_diff(s1_x_r, kept_x_r);
    ay      = abs_diff(s1_y_r, kept_y_r);
    az      = abs_diff(s1_z_r, kept_z_r);
    sq_x    = ax * ax;
    sq_y    = ay * ay;
    sq_z    = az * az;
    dist_sq = SUM_WIDTH'(sq_x) + SUM_WIDTH'(sq_y) + SUM_WIDTH'(sq_z);
    far     = CMP_WIDTH'(dist_sq) > CMP_WIDTH'(thresh_r);

    phase     = s1_start_r ? '0 : phase_r;
    phase_inc = {1'b0, phase} + 1'b1;
    phase_nxt = (phase_inc >= {1'b0, step_r}) ? '0 : phase_inc[STEP_WIDTH-1:0];

    unique case (mode_r)
      MODE_STEP: keep_nxt = (phase == '0) | s1_end_r;
      MODE_DIST: keep_nxt = s1_start_r | far;
      default:   keep_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kept_x_r <= '0;
      kept_y_r <= '0;
      kept_z_r <= '0;
      phase_r  <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      if (keep_nxt) begin
        kept_x_r <= s1_x_r;
        kept_y_r <= s1_y_r;
        kept_z_r <= s1_z_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_x_r    <= s1_x_r;
      out_y_r    <= s1_y_r;
      out_z_r    <= s1_z_r;
      out_keep_r <= keep_nxt;
      out_end_r  <= s1_end_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_keep_r;
  assign out_tlast  = out_end_r;

  generate
    if (PAD_WIDTH > 0) begin : g_pad
      assign out_tdata = {{PAD_WIDTH{1'b0}}, out_z_r, out_y_r, out_x_r};
    end else begin : g_nopad
      assign out_tdata = {out_z_r, out_y_r, out_x_r};
    end
  endgenerate

endmodule

// ===== src/ppd_checker.sv =====
// ----------------------------------------------------------------------------
// ppd_checker
// Port-level checks for the path point downsampler, bound to the top level.
// ----------------------------------------------------------------------------
module ppd_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  input  logic                                in_tready,
  input  logic [ppd_pkg::DATA_WIDTH-1:0]      in_tdata,
  input  logic                                in_tlast,
  input  logic                                in_tuser,
  input  logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic [ppd_pkg::DATA_WIDTH-1:0]      out_tdata,
  input  logic                                out_tlast,
  input  logic                                out_tuser,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [ppd_pkg::CFG_ADDR_WIDTH-1:0]  cfg_paddr,
  input  logic [ppd_pkg::CFG_DATA_WIDTH-1:0]  cfg_pwdata,
  input  logic [ppd_pkg::CFG_DATA_WIDTH-1:0]  cfg_prdata,
  input  logic                                cfg_pready
);
  import ppd_pkg::*;

  // points accepted but not yet delivered
  logic [1:0] pend_r;
  logic       in_x, out_x;

  assign in_x  = in_tvalid & in_tready;
  assign out_x = out_tvalid & out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + {1'b0, in_x} - {1'b0, out_x};
    end
  end

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("pipeline not empty after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output backpressure");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("more than two points in flight");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> pend_r != 2'd0)
    else $error("result without accepted point");

endmodule

bind path_point_downsampler ppd_checker u_ppd_checker (.*);

// ===== dv/path_point_downsampler_tb.sv =====
// ----------------------------------------------------------------------------
// path_point_downsampler_tb
// Streams framed 3D paths through the downsampler under both keep modes and a
// range of register settings. A clocked driver and monitor add random idles
// and stalls. Every result's keep flag, coordinates and end marker are checked
// against a predictor that tracks the point index and the last kept point.
// ----------------------------------------------------------------------------
module path_point_downsampler_tb;
  import ppd_pkg::*;

  localparam int CW = COORD_WIDTH;

  typedef logic signed [CW-1:0] coord_t;

  localparam coord_t C_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam coord_t C_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [THRESH_WIDTH-1:0] THRESH_MAX = '1;

  typedef struct {
    coord_t x, y, z;
    logic   first;
    logic   last;
    bit     drain;
  } point_t;

  typedef struct {
    logic   keep;
    coord_t x, y, z;
    logic   last;
  } verdict_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_tvalid = 1'b0;
  logic                      in_tready;
  // in_tdata: x_pos, y_pos, z_pos (lowest bits first)
  logic [DATA_WIDTH-1:0]     in_tdata = '0;
  logic                      in_tlast = 1'b0;
  // in_tuser: path_start
  logic                      in_tuser = 1'b0;
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  // out_tdata: out_x, out_y, out_z (lowest bits first)
  logic [DATA_WIDTH-1:0]     out_tdata;
  logic                      out_tlast;
  // out_tuser: keep
  logic                      out_tuser;
  logic                      cfg_psel = 1'b0;
  logic                      cfg_penable = 1'b0;
  logic                      cfg_pwrite = 1'b0;
  logic [CFG_ADDR_WIDTH-1:0] cfg_paddr = '0;
  logic [CFG_DATA_WIDTH-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_WIDTH-1:0] cfg_prdata;
  logic                      cfg_pready;

  path_point_downsampler dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor copy of the registers and state
  mode_t                   cfg_mode = MODE_STEP;
  logic [STEP_WIDTH-1:0]   cfg_step = STEP_RESET;
  logic [THRESH_WIDTH-1:0] cfg_thresh = THRESH_RESET;
  coord_t                  anchor_x = '0;
  coord_t                  anchor_y = '0;
  coord_t                  anchor_z = '0;
  logic [STEP_WIDTH-1:0]   point_idx = '0;

  point_t   point_q[$];
  verdict_t verdict_q[$];
  point_t   cur_pt;
  coord_t   walk_x = '0;
  coord_t   walk_y = '0;
  coord_t   walk_z = '0;

  int gap_left = 0;
  int stall_left = 0;
  bit tx_idle_on = 1'b1;
  bit rx_stall_on = 1'b1;
  int n_sent = 0;
  int n_results = 0;
  int n_kept = 0;
  int n_mismatch = 0;
  int n_paths = 0;
  int n_cfg = 0;

  function automatic verdict_t downsample_point(point_t p);
    verdict_t              v;
    logic [STEP_WIDTH-1:0] idx;
    logic [STEP_WIDTH:0]   nxt;
    longint                dx, dy, dz;
    logic [63:0]           d2;
    idx = p.first ? '0 : point_idx;
    if (cfg_mode == MODE_STEP) begin
      v.keep = (idx == '0) || p.last;
    end else if (p.first) begin
      v.keep = 1'b1;
    end else begin
      dx = longint'(p.x) - longint'(anchor_x);
      dy = longint'(p.y) - longint'(anchor_y);
      dz = longint'(p.z) - longint'(anchor_z);
      d2 = dx * dx + dy * dy + dz * dz;
      v.keep = d2 > 64'(cfg_thresh);
    end
    if (v.keep) begin
      anchor_x = p.x;
      anchor_y = p.y;
      anchor_z = p.z;
    end
    nxt = idx + 1'b1;
    point_idx = (nxt >= {1'b0, cfg_step}) ? '0 : nxt[STEP_WIDTH-1:0];
    v.x = p.x;
    v.y = p.y;
    v.z = p.z;
    v.last = p.last;
    return v;
  endfunction

  function automatic int pick_idle(bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic coord_t move_coord(coord_t c, int style);
    case (style)
      0: return c + coord_t'(int'($urandom_range(1400)) - 700);
      1: return coord_t'($urandom);
      default: begin
        case ($urandom_range(4))
          0: return C_MIN;
          1: return C_MAX;
          2: return '0;
          3: return '1;
          default: return coord_t'(1);
        endcase
      end
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    n_mismatch++;
    if (n_mismatch <= 10) $display("MISMATCH: %s", msg);
  endtask

  task automatic push_point(coord_t x, coord_t y, coord_t z, bit first, bit last,
                            bit drain);
    point_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    p.first = first;
    p.last = last;
    p.drain = drain;
    point_q = {point_q, p};
  endtask

  task automatic push_path(int len, bit with_start, bit with_end, int style);
    for (int i = 0; i < len; i++) begin
      walk_x = move_coord(walk_x, ($urandom_range(24) == 0) ? 1 : style);
      walk_y = move_coord(walk_y, ($urandom_range(24) == 0) ? 1 : style);
      walk_z = move_coord(walk_z, ($urandom_range(24) == 0) ? 1 : style);
      push_point(walk_x, walk_y, walk_z, with_start && i == 0,
                 with_end && i == len - 1, $urandom_range(299) == 0);
    end
    n_paths++;
  endtask

  task automatic random_phase(int n_points);
    int pushed, len, style, r;
    pushed = 0;
    while (pushed < n_points) begin
      r = $urandom_range(99);
      len = (r < 70) ? $urandom_range(12, 1) :
            (r < 95) ? $urandom_range(40, 13) : $urandom_range(120, 41);
      r = $urandom_range(99);
      style = (r < 70) ? 0 : (r < 90) ? 1 : 2;
      push_path(len, $urandom_range(9) != 0, $urandom_range(9) != 0, style);
      pushed += len;
    end
  endtask

  task automatic apb_access(reg_idx_t idx, bit wr, logic [63:0] wdata,
                            output logic [63:0] rdata);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= CFG_ADDR_WIDTH'(int'(idx) * 8);
    cfg_pwdata <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic write_reg(reg_idx_t idx, logic [63:0] val);
    logic [63:0] rd, want;
    apb_access(idx, 1'b1, val, rd);
    case (idx)
      REG_MODE: begin
        cfg_mode = mode_t'(val[0]);
        want = 64'(val[0]);
      end
      REG_STEP: begin
        cfg_step = val[STEP_WIDTH-1:0];
        want = 64'(val[STEP_WIDTH-1:0]);
      end
      default: begin
        cfg_thresh = val[THRESH_WIDTH-1:0];
        want = 64'(val[THRESH_WIDTH-1:0]);
      end
    endcase
    apb_access(idx, 1'b0, '0, rd);
    if (rd !== want)
      report_mismatch($sformatf("register %s readback: expected 0x%0h, got 0x%0h",
                                idx.name(), want, rd));
    n_cfg++;
  endtask

  task automatic set_config(mode_t m, logic [STEP_WIDTH-1:0] s,
                            logic [THRESH_WIDTH-1:0] t);
    write_reg(REG_MODE, 64'(m));
    write_reg(REG_STEP, 64'(s));
    write_reg(REG_THRESH, 64'(t));
  endtask

  task automatic wait_idle();
    while (point_q.size() > 0 || in_tvalid || verdict_q.size() > 0) @(negedge clk);
    repeat (6) @(posedge clk);
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        verdict_q = {verdict_q, downsample_point(cur_pt)};
        n_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          in_tvalid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (point_q.size() > 0 && !(point_q[0].drain && verdict_q.size() > 0)) begin
          cur_pt = point_q.pop_front();
          in_tdata <= DATA_WIDTH'({cur_pt.z, cur_pt.y, cur_pt.x});
          in_tuser <= cur_pt.first;
          in_tlast <= cur_pt.last;
          in_tvalid <= 1'b1;
          gap_left <= pick_idle(tx_idle_on);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : rx_mon
    verdict_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        n_results++;
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("result %0d with nothing expected", n_results));
        end else begin
          want = verdict_q.pop_front();
          if (want.keep) n_kept++;
          if (out_tuser !== want.keep || out_tdata[CW-1:0] !== want.x ||
              out_tdata[2*CW-1:CW] !== want.y || out_tdata[3*CW-1:2*CW] !== want.z ||
              out_tlast !== want.last)
            report_mismatch($sformatf(
              "result %0d: expected keep=%0b (%0d,%0d,%0d) last=%0b, got keep=%0b (%0d,%0d,%0d) last=%0b",
              n_results, want.keep, want.x, want.y, want.z, want.last, out_tuser,
              $signed(out_tdata[CW-1:0]), $signed(out_tdata[2*CW-1:CW]),
              $signed(out_tdata[3*CW-1:2*CW]), out_tlast));
        end
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (rx_stall_on && $urandom_range(99) < 20) begin
        out_tready <= 1'b0;
        stall_left <= pick_idle(1'b1);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [STEP_WIDTH-1:0]   s;
    logic [THRESH_WIDTH-1:0] t;
    int                      r;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: stray point, single-point path, step-mode path
    push_point(C_MIN, C_MAX, '1, 1'b0, 1'b0, 1'b0);
    push_point(C_MAX, C_MIN, '0, 1'b1, 1'b1, 1'b0);
    push_path(9, 1'b1, 1'b1, 0);
    wait_idle();

    // distance mode, zero threshold: equal points dropped, end not forced
    write_reg(REG_MODE, 64'(MODE_DIST));
    write_reg(REG_THRESH, '0);
    push_point('0, '0, '0, 1'b1, 1'b0, 1'b0);
    push_point('0, '0, '0, 1'b0, 1'b0, 1'b0);
    push_point(coord_t'(1), '0, '0, 1'b0, 1'b0, 1'b1);
    push_point(coord_t'(1), '0, '0, 1'b0, 1'b0, 1'b0);
    push_point(C_MAX, C_MAX, C_MAX, 1'b0, 1'b0, 1'b0);
    push_point(C_MIN, C_MIN, C_MIN, 1'b0, 1'b0, 1'b0);
    push_point(C_MIN, C_MIN, C_MIN, 1'b0, 1'b1, 1'b0);
    wait_idle();

    // full-scale threshold: even corner to corner stays below
    write_reg(REG_THRESH, 64'(THRESH_MAX));
    push_point(C_MIN, C_MIN, C_MIN, 1'b1, 1'b0, 1'b0);
    push_point(C_MAX, C_MAX, C_MAX, 1'b0, 1'b0, 1'b0);
    push_point(C_MAX, C_MIN, C_MAX, 1'b0, 1'b1, 1'b0);
    wait_idle();

    for (int ph = 0; ph < 13; ph++) begin
      tx_idle_on = (ph % 5 != 1) && (ph % 5 != 3);
      rx_stall_on = (ph % 5 != 2) && (ph % 5 != 3);
      case (ph)
        0: set_config(MODE_STEP, '0, THRESH_RESET);
        1: set_config(MODE_STEP, '1, THRESH_RESET);
        2: set_config(MODE_STEP, STEP_WIDTH'(1), THRESH_RESET);
        3: set_config(MODE_DIST, STEP_WIDTH'(3), THRESH_MAX);
        4: set_config(MODE_DIST, STEP_WIDTH'(7), '0);
        default: begin
          r = $urandom_range(9);
          s = (r == 0) ? '0 : (r == 1) ? STEP_WIDTH'(1) : (r == 2) ? '1 :
              (r < 6) ? STEP_WIDTH'($urandom_range(6, 2)) : STEP_WIDTH'($urandom_range(40, 7));
          r = $urandom_range(9);
          t = (r == 0) ? '0 : (r == 1) ? THRESH_MAX :
              (r == 2) ? THRESH_WIDTH'({$urandom, $urandom}) :
              THRESH_WIDTH'($urandom_range(2000000));
          set_config(mode_t'($urandom_range(1)), s, t);
        end
      endcase
      random_phase(135);
      wait_idle();
    end

    if (verdict_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", verdict_q.size()));
    $display("Run covered %0d points in %0d paths, %0d results checked (%0d kept), %0d register writes.",
             n_sent, n_paths, n_results, n_kept, n_cfg);
    $display("Both modes, step sizes 0, 1 and 65535, zero and full-scale thresholds, random idles and stalls.");
    if (n_mismatch == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", n_mismatch);
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #8000000;
    $display("Timeout");
    $display("TEST FAILED");
    $finish;
  end

endmodule
